// File: rtl/core/cprs_pkg.sv
// package for the class priority request scheduler
// holds shared constants, command and status codes and the sequencer state type
`timescale 1ns / 1ps
`default_nettype none
package cprs_pkg;
  localparam int FifoDepthDef = 32;
  localparam int ClassCountDef = 6;
  localparam int TagBitsDef = 8;
  localparam int QueueCount = 7;
  localparam int PassQ = 6;
  localparam logic [10:0] CntMax = 11'd2047;
  localparam logic [10:0] BusyKbg = 11'd26;
  localparam logic [10:0] IdleLimit = 11'd28;
  localparam logic [10:0] MidLimit = 11'd30;

  localparam logic [1:0] CmdInsert = 2'd0;
  localparam logic [1:0] CmdDispatch = 2'd1;
  localparam logic [1:0] CmdComplete = 2'd2;
  localparam logic [1:0] CmdTick = 2'd3;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StRefused = 3'd1;
  localparam logic [2:0] StFull = 3'd2;
  localparam logic [2:0] StNone = 3'd3;
  localparam logic [2:0] StSpurious = 3'd4;

  localparam logic [2:0] RegAdmit = 3'd0;
  localparam logic [2:0] RegBusyBg = 3'd1;
  localparam logic [2:0] RegHold = 3'd2;
  localparam logic [2:0] RegEnable = 3'd3;
  localparam logic [2:0] RegExpire = 3'd4;
  localparam logic [2:0] RegQuiet = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_READ, S_EXEC, S_CTRL, S_OUT
  } state_t;
endpackage
`default_nettype wire

// File: rtl/core/class_priority_request_scheduler_core.sv
// class priority request scheduler, top level
// uses cprs_pkg and cprs_ram (one shared ram for all seven class queues)
//
// usage: one command word enters on in_valid/in_stall: insert (class, tag),
// dispatch attempt, completion (class) or one time tick. each command gives
// exactly one result word on out_valid/out_stall with status, dispatched
// tag and class, expiry flag, kick and the saturating expiry count.
// a command runs on a small sequencer. insert, tick and completion pass
// through exec, ctrl and out before their result shows; a new command is
// only taken once the result word has left. a dispatch reads the queue
// heads one at a time (address, then registered ram data) through the
// single ram read port and the shared compare unit: the passthrough head
// alone, or up to six heads in the expiry scan and six in the normal
// scan, then passes through exec, ctrl and out like the other commands.
// in_stall is high from acceptance until the result word is taken.
// a stalled result word holds still in the output register.
// configuration writes on cfg_valid/cfg_ready are always taken.
// reset (rst_n low, synchronous) empties all queues and counters, restores
// register defaults and sets the class 3 and class 4/5 limits to 28.
// queue storage is not cleared; entries are only read while occupied.
`timescale 1ns / 1ps
`default_nettype none
module class_priority_request_scheduler_core
  import cprs_pkg::*;
#(
  parameter int FIFO_DEPTH = FifoDepthDef,
  parameter int TAG_BITS = TagBitsDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [2:0]  in_req_class,
  input  wire logic [7:0]  in_req_tag,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [7:0]       out_out_tag,
  output logic [2:0]       out_out_class,
  output logic             out_was_expired,
  output logic             out_kick,
  output logic [15:0]      out_expired_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int AW = $clog2(QueueCount * FIFO_DEPTH);
  localparam int EW = TAG_BITS + 32;

  // config
  logic [10:0] admit_r, busybg_r;
  logic [9:0]  holdt_r, enable_r;
  logic [15:0] expire_r, quiet_r;

  logic [PW-1:0] head_r [QueueCount];
  logic [CW-1:0] cnt_r [QueueCount];
  logic [10:0]   cinf_r [6];
  logic [10:0]   tinf_r, tq_r, c3lim_r, c45lim_r;
  logic [31:0]   now_r, topdl_r, highdl_r, lasthi_r;
  logic          topbusy_r, highbusy_r, lastexp_r, hold_r, antic_r;
  logic [15:0]   exptot_r;
  logic [9:0]    holdrem_r;

  state_t        state_r, state_nxt;
  logic [1:0]    cmd_r;
  logic [2:0]    cls_r;
  logic [TAG_BITS-1:0] tag_r;
  logic [2:0]    q_r;        // scan index
  logic          phase_r;    // 0 expiry scan, 1 normal scan
  logic [2:0]    sel_r;      // queue chosen
  logic          selexp_r;

  logic [2:0]  ost_r;
  logic [7:0]  otag_r;
  logic [2:0]  ocls_r;
  logic        oexp_r, okick_r, ovalid_r;

  // ram
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  cprs_ram #(.Width(EW), .Depth(QueueCount * FIFO_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_stall = (state_r != S_IDLE) || ovalid_r;
  assign out_valid = ovalid_r;
  assign out_status = ost_r;
  assign out_out_tag = otag_r;
  assign out_out_class = ocls_r;
  assign out_was_expired = oexp_r;
  assign out_kick = okick_r;
  assign out_expired_count = exptot_r;

  function automatic logic [AW-1:0] addr_of(input logic [2:0] q, input logic [PW-1:0] p);
    addr_of = AW'(AW'(q) * AW'(FIFO_DEPTH) + AW'(p));
  endfunction

  // insert helpers
  logic [10:0] adm_lim;
  logic [13:0] lim3;
  logic [11:0] used;
  logic [2:0]  wq;
  logic [CW:0] wsum;
  logic [PW-1:0] wpos;
  always_comb begin
    lim3 = {3'b0, admit_r} * 14'd3;
    case (cls_r)
      3'd1, 3'd2: adm_lim = admit_r - {3'b0, admit_r[10:3]};
      3'd3: adm_lim = admit_r - {2'b0, admit_r[10:2]};
      3'd4: adm_lim = admit_r - lim3[13:3];
      3'd5: adm_lim = {1'b0, admit_r[10:1]};
      default: adm_lim = admit_r;
    endcase
    used = {1'b0, tinf_r} + {1'b0, tq_r};
    wq = (cls_r == 3'd7) ? 3'd0 : cls_r;
    wsum = (CW+1)'(head_r[wq]) + (CW+1)'(cnt_r[wq]);
    if (wsum >= (CW+1)'(FIFO_DEPTH)) wpos = PW'(wsum - (CW+1)'(FIFO_DEPTH));
    else wpos = PW'(wsum);
  end

  // scan helpers
  logic [10:0] qlim;
  logic        qnolim, qok, qexp;
  logic [31:0] ddiff;
  always_comb begin
    qnolim = (q_r == 3'd0);
    case (q_r)
      3'd1, 3'd2: qlim = MidLimit;
      3'd3: qlim = c3lim_r;
      default: qlim = c45lim_r;
    endcase
    qok = (cnt_r[q_r] != '0) && (qnolim || tinf_r < qlim);
    ddiff = rdata[31:0] - now_r;
    qexp = (ddiff == 32'd0) || ddiff[31];
  end

  logic [13:0] csum;
  always_comb begin
    csum = '0;
    for (int i = 0; i < 6; i++) csum = csum + 14'(cinf_r[i]);
  end

  logic [31:0] gap;
  assign gap = now_r - lasthi_r;

  always_comb begin
    we = 1'b0;
    waddr = addr_of(cls_r, wpos);
    wdata = {tag_r, now_r + {16'b0, expire_r}};
    raddr = addr_of(q_r, head_r[q_r]);
    if (state_r == S_EXEC && cmd_r == CmdInsert && cls_r != 3'd7 &&
        !(used >= {1'b0, adm_lim}) && cnt_r[cls_r] < CW'(FIFO_DEPTH)) begin
      we = 1'b1;
    end
  end

  // another head has to be read before the dispatch can be decided
  logic rescan;
  always_comb begin
    rescan = 1'b0;
    if (sel_r == 3'd7) begin
      if (!phase_r) rescan = !(cnt_r[q_r] != '0 && qexp);
      else rescan = !(q_r == 3'd3 && (hold_r || antic_r)) && !qok && (q_r != 3'd5);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid && !in_stall) state_nxt = (in_cmd == CmdDispatch) ? S_SCAN : S_EXEC;
      S_SCAN: state_nxt = S_READ;
      S_READ: state_nxt = rescan ? S_SCAN : S_EXEC;
      S_EXEC: state_nxt = S_CTRL;
      S_CTRL: state_nxt = S_OUT;
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and control updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      admit_r <= 11'd128; busybg_r <= 11'd24; holdt_r <= 10'd1; enable_r <= 10'd5;
      expire_r <= 16'd500; quiet_r <= 16'd200;
      for (int i = 0; i < QueueCount; i++) begin
        head_r[i] <= '0; cnt_r[i] <= '0;
      end
      for (int i = 0; i < 6; i++) cinf_r[i] <= '0;
      tinf_r <= '0; tq_r <= '0; now_r <= '0;
      c3lim_r <= IdleLimit; c45lim_r <= IdleLimit;
      topbusy_r <= 1'b0; highbusy_r <= 1'b0; lastexp_r <= 1'b0;
      hold_r <= 1'b0; antic_r <= 1'b0; topdl_r <= '0; highdl_r <= '0;
      exptot_r <= '0; holdrem_r <= '0; lasthi_r <= '0;
      ovalid_r <= 1'b0; q_r <= '0; phase_r <= 1'b0; sel_r <= '0; selexp_r <= 1'b0;
      cmd_r <= '0; cls_r <= '0; tag_r <= '0;
      ost_r <= '0; otag_r <= '0; ocls_r <= '0; oexp_r <= 1'b0; okick_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          RegAdmit: admit_r <= cfg_data[10:0];
          RegBusyBg: busybg_r <= cfg_data[10:0];
          RegHold: holdt_r <= cfg_data[9:0];
          RegEnable: enable_r <= cfg_data[9:0];
          RegExpire: expire_r <= cfg_data;
          RegQuiet: quiet_r <= cfg_data;
          default: ;
        endcase
      end
      if (ovalid_r && !out_stall) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            cmd_r <= in_cmd; cls_r <= in_req_class; tag_r <= in_req_tag[TAG_BITS-1:0];
            ost_r <= StOk; otag_r <= '0; ocls_r <= '0; oexp_r <= 1'b0; okick_r <= 1'b0;
            selexp_r <= 1'b0;
            if (cnt_r[PassQ] != '0) begin
              q_r <= 3'(PassQ); phase_r <= 1'b1; sel_r <= 3'(PassQ);
            end else begin
              q_r <= 3'd0; phase_r <= lastexp_r; sel_r <= 3'd7;
            end
          end
        end
        S_SCAN: begin
          // one queue per pass: head read issued here, checked in S_READ
        end
        S_READ: begin
          // sequential scan loops back through SCAN
          if (sel_r == 3'd7) begin
            if (!phase_r) begin
              if (cnt_r[q_r] != '0 && qexp) begin
                sel_r <= q_r; selexp_r <= 1'b1;
              end else if (q_r == 3'd5) begin
                q_r <= 3'd0; phase_r <= 1'b1;
              end else begin
                q_r <= q_r + 3'd1;
              end
            end else begin
              if (q_r == 3'd3 && (hold_r || antic_r)) begin
                // held back: stop the scan
              end else if (qok) begin
                sel_r <= q_r;
              end else if (q_r != 3'd5) begin
                q_r <= q_r + 3'd1;
              end
            end
          end
        end
        S_EXEC: begin
          case (cmd_r)
            CmdInsert: begin
              if (cls_r == 3'd7 || used >= {1'b0, adm_lim}) ost_r <= StRefused;
              else if (cnt_r[cls_r] >= CW'(FIFO_DEPTH)) ost_r <= StFull;
              else begin
                cnt_r[cls_r] <= cnt_r[cls_r] + 1'b1;
                if (tq_r != CntMax) tq_r <= tq_r + 1'b1;
                if (cls_r <= 3'd2) begin
                  hold_r <= 1'b0; holdrem_r <= '0;
                  if (gap[31]) antic_r <= 1'b0;
                  else begin
                    antic_r <= gap < {22'b0, enable_r};
                    lasthi_r <= now_r;
                  end
                end
              end
            end
            CmdDispatch: begin
              if (sel_r == 3'd7) begin
                ost_r <= StNone;
                if (!hold_r && antic_r && q_r >= 3'd2 && phase_r) begin
                  hold_r <= 1'b1; holdrem_r <= holdt_r;
                end
              end else begin
                otag_r <= 8'(rdata[EW-1:32]);
                ocls_r <= sel_r; oexp_r <= selexp_r;
                if (head_r[sel_r] == PW'(FIFO_DEPTH - 1)) head_r[sel_r] <= '0;
                else head_r[sel_r] <= head_r[sel_r] + 1'b1;
                cnt_r[sel_r] <= cnt_r[sel_r] - 1'b1;
                if (tq_r != '0) tq_r <= tq_r - 1'b1;
                if (tinf_r != CntMax) tinf_r <= tinf_r + 1'b1;
                if (sel_r != 3'(PassQ)) begin
                  if (cinf_r[sel_r] != CntMax) cinf_r[sel_r] <= cinf_r[sel_r] + 1'b1;
                  if (selexp_r) begin
                    lastexp_r <= 1'b1;
                    if (exptot_r != 16'hFFFF) exptot_r <= exptot_r + 1'b1;
                  end else begin
                    lastexp_r <= 1'b0;
                    if (sel_r <= 3'd2) begin
                      hold_r <= 1'b0; holdrem_r <= '0;
                    end
                  end
                end
              end
            end
            CmdComplete: begin
              if (cls_r == 3'd7 || tinf_r == '0 ||
                  (cls_r < 3'd6 && cinf_r[cls_r] == '0) ||
                  (cls_r == 3'(PassQ) && 14'(tinf_r) <= csum)) begin
                ost_r <= StSpurious;
              end else begin
                tinf_r <= tinf_r - 1'b1;
                okick_r <= (tinf_r == 11'd1) && (tq_r != '0);
                if (cls_r < 3'd6) cinf_r[cls_r] <= cinf_r[cls_r] - 1'b1;
              end
            end
            default: begin
              now_r <= now_r + 1'b1;
              if (hold_r) begin
                if (holdrem_r <= 10'd1) begin
                  hold_r <= 1'b0; holdrem_r <= '0; antic_r <= 1'b0;
                  okick_r <= (tq_r != '0);
                end else holdrem_r <= holdrem_r - 1'b1;
              end
            end
          endcase
        end
        S_CTRL: begin
          // busy tracking after inflight changes of classes 0 to 5
          if ((cmd_r == CmdDispatch && sel_r < 3'd6) ||
              (cmd_r == CmdComplete && ost_r == StOk && cls_r < 3'd6)) begin
            if (topbusy_r) begin
              if (cinf_r[0] == '0) begin
                topbusy_r <= 1'b0; topdl_r <= now_r + {16'b0, quiet_r};
              end
            end else if (cinf_r[0] != '0) begin
              topbusy_r <= 1'b1; c3lim_r <= BusyKbg;
            end else if (topdl_r - now_r > 32'h7FFF_FFFF) begin
              c3lim_r <= IdleLimit;
            end
            if (highbusy_r) begin
              if (cinf_r[0] == '0 && cinf_r[1] == '0) begin
                highbusy_r <= 1'b0; highdl_r <= now_r + {16'b0, quiet_r};
              end
            end else if (cinf_r[0] != '0 || cinf_r[1] != '0) begin
              highbusy_r <= 1'b1; c45lim_r <= busybg_r;
            end else if (highdl_r - now_r > 32'h7FFF_FFFF) begin
              c45lim_r <= IdleLimit;
            end
          end
        end
        S_OUT: ovalid_r <= 1'b1;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/cprs_ram.sv
// generic simple dual port ram (one write port, one read port) with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module cprs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
